// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

  // Device capacity and derived bitmap geometry
  localparam int MAX_BLOCKS = 4096;
  localparam int CFG_W      = 13;
  localparam int BLK_W      = 12;
  localparam int MODE_W     = 2;
  localparam int BIT_W      = 5;
  localparam int ROW_BITS   = 1 << BIT_W;
  localparam int ROWS       = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register file
  localparam int APB_AW = 3;
  localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [CFG_W-1:0] FIRST_RST = 13'd2;
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_FIRST = 1'b1;

  // Request mode codes on the input channel
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd3;

  typedef enum logic [2:0] {
    OP_SET,
    OP_CLEAR,
    OP_TEST,
    OP_FIND,
    OP_ERR
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Classified request: row/bit of the block (or of the search start for a find)
  // and the row/bit of the last block on the device
  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row;
    logic [BIT_W-1:0] bit_idx;
    logic [ROW_W-1:0] end_row;
    logic [BIT_W-1:0] end_bit;
  } cmd_t;

  // Index of the lowest set bit of a row word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [ROW_BITS-1:0] v);
    logic [ROW_BITS-1:0] iso;
    logic [BIT_W-1:0]    idx;
    iso = v & (~v + ROW_BITS'(1));
    idx = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bitmap_free_block_allocator_unit.sv =====
// Each request leaves the queue for the back end, which steps through fetch, evaluate and
// deliver (ST_READ, ST_EVAL, ST_DONE); an out-of-range request goes straight to deliver, and a
// find evaluates one 32-block row after another, over up to all 128 rows. The back end works on
// one request at a time and holds in deliver while the output stalls; a two-entry queue
// takes requests while the back end works. Reset (synchronous, active low) frees every
// block at once through per-row valid bits and loads total_blocks 4096, first_data_block 2.
module bitmap_free_block_allocator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfa_pkg::MODE_W-1:0]   in_mode,
  input  logic [bfa_pkg::BLK_W-1:0]    in_block,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_bit_value,
  output logic [bfa_pkg::BLK_W-1:0]    out_found_block,
  output logic                         out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfa_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [bfa_pkg::CFG_W-1:0] cfg_total_r;
  logic [bfa_pkg::CFG_W-1:0] cfg_first_r;
  logic                      cfg_wr;
  logic                      q_valid;
  logic                      q_pop;
  bfa_pkg::cmd_t             q_cmd;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_r <= bfa_pkg::TOTAL_RST;
      cfg_first_r <= bfa_pkg::FIRST_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bfa_pkg::REG_TOTAL: cfg_total_r <= pwdata[bfa_pkg::CFG_W-1:0];
        default:            cfg_first_r <= pwdata[bfa_pkg::CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bfa_pkg::REG_FIRST: prdata = 32'(cfg_first_r);
      default:            prdata = 32'(cfg_total_r);
    endcase
  end

  bfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_block  (in_block),
    .cfg_total (cfg_total_r),
    .cfg_first (cfg_first_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  bfa_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_found_block (out_found_block),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/bfa_front.sv =====
module bfa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfa_pkg::MODE_W-1:0]   in_mode,
  input  logic [bfa_pkg::BLK_W-1:0]    in_block,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_total,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_first,
  output logic                         q_valid,
  output bfa_pkg::cmd_t                q_cmd,
  input  logic                         q_pop
);

  logic [bfa_pkg::CFG_W-1:0] n_blocks;
  logic [bfa_pkg::CFG_W-1:0] last_blk;
  bfa_pkg::cmd_t             cmd;

  bfa_pkg::cmd_t               q_mem_r [bfa_pkg::QDEPTH];
  logic [bfa_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bfa_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bfa_pkg::QPTR_W:0]    count_r, count_nxt;
  logic                        push;
  logic                        pop;

  // Saturate the block count at device capacity
  always_comb begin
    if (32'(cfg_total) > bfa_pkg::MAX_BLOCKS) begin
      n_blocks = bfa_pkg::CFG_W'(bfa_pkg::MAX_BLOCKS);
    end else begin
      n_blocks = cfg_total;
    end
    last_blk = n_blocks - bfa_pkg::CFG_W'(1);
  end

  // Classify the request and range-check it
  always_comb begin
    cmd.end_row = bfa_pkg::ROW_W'(last_blk >> bfa_pkg::BIT_W);
    cmd.end_bit = last_blk[bfa_pkg::BIT_W-1:0];
    if (in_mode == bfa_pkg::MODE_FIND) begin
      cmd.row     = bfa_pkg::ROW_W'(cfg_first >> bfa_pkg::BIT_W);
      cmd.bit_idx = cfg_first[bfa_pkg::BIT_W-1:0];
      cmd.op      = (cfg_first >= n_blocks) ? bfa_pkg::OP_ERR : bfa_pkg::OP_FIND;
    end else begin
      cmd.row     = bfa_pkg::ROW_W'(in_block >> bfa_pkg::BIT_W);
      cmd.bit_idx = in_block[bfa_pkg::BIT_W-1:0];
      if (bfa_pkg::CFG_W'(in_block) >= n_blocks) begin
        cmd.op = bfa_pkg::OP_ERR;
      end else begin
        unique case (in_mode)
          bfa_pkg::MODE_SET:   cmd.op = bfa_pkg::OP_SET;
          bfa_pkg::MODE_CLEAR: cmd.op = bfa_pkg::OP_CLEAR;
          default:             cmd.op = bfa_pkg::OP_TEST;
        endcase
      end
    end
  end

  // Queue control
  assign in_ready = (count_r != (bfa_pkg::QPTR_W + 1)'(bfa_pkg::QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bfa_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + bfa_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (bfa_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (bfa_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified request
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== rtl/bfa_back.sv =====
module bfa_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bfa_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_bit_value,
  output logic [bfa_pkg::BLK_W-1:0]  out_found_block,
  output logic                       out_status
);

  bfa_pkg::state_t              state_r, state_nxt;
  bfa_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [bfa_pkg::ROW_W-1:0]    scan_row_r, scan_row_nxt;
  logic                         first_r, first_nxt;
  logic                         res_bit_r, res_bit_nxt;
  logic [bfa_pkg::BLK_W-1:0]    res_found_r, res_found_nxt;
  logic                         res_status_r, res_status_nxt;
  logic                         out_valid_r;
  logic                         out_bit_r;
  logic [bfa_pkg::BLK_W-1:0]    out_found_r;
  logic                         out_status_r;

  logic [bfa_pkg::ROW_BITS-1:0] mem [bfa_pkg::ROWS];
  logic [bfa_pkg::ROWS-1:0]     valid_r;
  logic [bfa_pkg::ROW_BITS-1:0] rd_data_r;
  logic                         rd_vld_r;
  logic [bfa_pkg::ROW_W-1:0]    rd_addr;
  logic                         mem_we;
  logic [bfa_pkg::ROW_BITS-1:0] mem_wdata;

  logic [bfa_pkg::ROW_BITS-1:0] row_data;
  logic [bfa_pkg::ROW_BITS-1:0] lo_mask;
  logic [bfa_pkg::ROW_BITS-1:0] hi_mask;
  logic [bfa_pkg::ROW_BITS-1:0] cand;
  logic [bfa_pkg::ROW_BITS-1:0] bit_mask;
  logic [bfa_pkg::BIT_W-1:0]    hit_idx;
  logic                         hit;
  logic                         out_free;
  logic                         out_load;

  // Rows never written read as all free
  assign row_data = rd_vld_r ? rd_data_r : '0;
  assign bit_mask = bfa_pkg::ROW_BITS'(1) << cmd_r.bit_idx;

  // Free bits of the current row inside the search window
  always_comb begin
    lo_mask = first_r ? ({bfa_pkg::ROW_BITS{1'b1}} << cmd_r.bit_idx)
                      : {bfa_pkg::ROW_BITS{1'b1}};
    hi_mask = (scan_row_r == cmd_r.end_row)
              ? ({bfa_pkg::ROW_BITS{1'b1}} >> (~cmd_r.end_bit))
              : {bfa_pkg::ROW_BITS{1'b1}};
    cand    = ~row_data & lo_mask & hi_mask;
    hit     = |cand;
    hit_idx = bfa_pkg::lowest_set(cand);
  end

  assign out_free = !out_valid_r || out_ready;

  // Sequencer: fetch row, evaluate or modify, scan on for a find, deliver
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    scan_row_nxt   = scan_row_r;
    first_nxt      = first_r;
    res_bit_nxt    = res_bit_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    rd_addr        = scan_row_r;
    mem_we         = 1'b0;
    mem_wdata      = row_data;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      bfa_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          scan_row_nxt   = q_cmd.row;
          first_nxt      = 1'b1;
          res_bit_nxt    = 1'b0;
          res_found_nxt  = '0;
          res_status_nxt = 1'b0;
          if (q_cmd.op == bfa_pkg::OP_ERR) begin
            res_status_nxt = 1'b1;
            state_nxt      = bfa_pkg::ST_DONE;
          end else begin
            state_nxt = bfa_pkg::ST_READ;
          end
        end
      end
      bfa_pkg::ST_READ: begin
        state_nxt = bfa_pkg::ST_EVAL;
      end
      bfa_pkg::ST_EVAL: begin
        unique case (cmd_r.op)
          bfa_pkg::OP_SET: begin
            mem_we    = 1'b1;
            mem_wdata = row_data | bit_mask;
            state_nxt = bfa_pkg::ST_DONE;
          end
          bfa_pkg::OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = row_data & ~bit_mask;
            state_nxt = bfa_pkg::ST_DONE;
          end
          bfa_pkg::OP_TEST: begin
            res_bit_nxt = row_data[cmd_r.bit_idx];
            state_nxt   = bfa_pkg::ST_DONE;
          end
          bfa_pkg::OP_FIND: begin
            if (hit) begin
              res_found_nxt = bfa_pkg::BLK_W'({scan_row_r, hit_idx});
              state_nxt     = bfa_pkg::ST_DONE;
            end else if (scan_row_r == cmd_r.end_row) begin
              res_status_nxt = 1'b1;
              state_nxt      = bfa_pkg::ST_DONE;
            end else begin
              // Advance and fetch the next row in the same cycle
              scan_row_nxt = scan_row_r + bfa_pkg::ROW_W'(1);
              rd_addr      = scan_row_nxt;
              first_nxt    = 1'b0;
            end
          end
          default: begin
            res_status_nxt = 1'b1;
            state_nxt      = bfa_pkg::ST_DONE;
          end
        endcase
      end
      bfa_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the working request and result
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    scan_row_r   <= scan_row_nxt;
    first_r      <= first_nxt;
    res_bit_r    <= res_bit_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_bit_r    <= res_bit_r;
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
    end
  end

  // Bitmap rows
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[scan_row_r] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Row valid bits: reset frees every block at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[scan_row_r] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_bit_r;
  assign out_found_block = out_found_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bfa_pkg::ST_DONE))
    else $error("result presented without completing a request");

  a_write_only_mark: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == bfa_pkg::ST_EVAL) &&
               (cmd_r.op == bfa_pkg::OP_SET || cmd_r.op == bfa_pkg::OP_CLEAR))
    else $error("bitmap written outside a mark request");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_found_r == '0) && !out_bit_r)
    else $error("error result carries nonzero fields");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfa_pkg::ST_EVAL && cmd_r.op == bfa_pkg::OP_FIND) |->
      (scan_row_r <= cmd_r.end_row))
    else $error("find scanned past the last row");

  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != bfa_pkg::ST_IDLE))
    else $error("request popped but sequencer stayed idle");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT_CYCLES   = 1500000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_REQUESTS = 210;
  localparam int PHASES         = 6;
  localparam int LAST_BLOCK     = bfa_pkg::MAX_BLOCKS - 1;

  typedef struct packed {
    logic                      bit_value;
    logic [bfa_pkg::BLK_W-1:0] found_block;
    logic                      status;
  } alloc_res_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_CHK,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       reg_sel;
    logic [bfa_pkg::CFG_W-1:0]  reg_val;
    logic [bfa_pkg::MODE_W-1:0] mode;
    logic [bfa_pkg::BLK_W-1:0]  block;
    alloc_res_t                 want;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [bfa_pkg::MODE_W-1:0] in_mode;
  logic [bfa_pkg::BLK_W-1:0]  in_block;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_bit_value;
  logic [bfa_pkg::BLK_W-1:0]  out_found_block;
  logic                       out_status;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bfa_pkg::APB_AW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // Shadow of the allocator: bitmap and both registers
  bit [0:bfa_pkg::MAX_BLOCKS-1] used_bits;
  logic [bfa_pkg::CFG_W-1:0]    total_q;
  logic [bfa_pkg::CFG_W-1:0]    first_q;

  alloc_res_t pending_results[$];
  alloc_res_t head_result;
  alloc_res_t last_result;
  plan_row_t  directed_plan[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         ready_left = 0;
  bit         ready_on = 1'b0;

  bitmap_free_block_allocator_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_block        (in_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_found_block (out_found_block),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  // Block count in use, saturated at capacity
  function automatic int block_limit();
    return (int'(total_q) > bfa_pkg::MAX_BLOCKS) ? bfa_pkg::MAX_BLOCKS : int'(total_q);
  endfunction

  // Apply one request to the shadow bitmap and return its result
  function automatic alloc_res_t predict_alloc(input logic [bfa_pkg::MODE_W-1:0] m,
                                               input logic [bfa_pkg::BLK_W-1:0] b);
    alloc_res_t r;
    int lim;
    bit hit;
    r = '0;
    hit = 1'b0;
    lim = block_limit();
    if (m == bfa_pkg::MODE_FIND) begin
      for (int i = int'(first_q); i < lim; i++) begin
        if (!hit && !used_bits[i]) begin
          hit = 1'b1;
          r.found_block = bfa_pkg::BLK_W'(i);
        end
      end
      r.status = !hit;
    end else if (int'(b) >= lim) begin
      r.status = 1'b1;
    end else begin
      case (m)
        bfa_pkg::MODE_SET:   used_bits[b] = 1'b1;
        bfa_pkg::MODE_CLEAR: used_bits[b] = 1'b0;
        default:             r.bit_value = used_bits[b];
      endcase
    end
    return r;
  endfunction

  // Block index: most often near the search start, some around the end of the block count, some in row 0, some anywhere
  function automatic logic [bfa_pkg::BLK_W-1:0] pick_block();
    int lim;
    int lo;
    int hi;
    int r;
    lim = block_limit();
    r = $urandom_range(99, 0);
    if (r < 30) begin
      return bfa_pkg::BLK_W'($urandom_range(LAST_BLOCK, 0));
    end else if (r < 75) begin
      lo = (int'(first_q) > LAST_BLOCK) ? LAST_BLOCK : int'(first_q);
      hi = (lo + 48 > LAST_BLOCK) ? LAST_BLOCK : lo + 48;
      return bfa_pkg::BLK_W'($urandom_range(hi, lo));
    end else if (r < 90) begin
      lo = (lim < 2) ? 0 : lim - 2;
      hi = (lim + 1 > LAST_BLOCK) ? LAST_BLOCK : lim + 1;
      if (lo > hi) lo = hi;
      return bfa_pkg::BLK_W'($urandom_range(hi, lo));
    end
    return bfa_pkg::BLK_W'($urandom_range(31, 0));
  endfunction

  function automatic logic [bfa_pkg::MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(99, 0);
    if (r < 40) return bfa_pkg::MODE_SET;
    if (r < 55) return bfa_pkg::MODE_CLEAR;
    if (r < 75) return bfa_pkg::MODE_TEST;
    return bfa_pkg::MODE_FIND;
  endfunction

  function automatic void plan_req(input row_kind_t kind,
                                   input logic [bfa_pkg::MODE_W-1:0] m,
                                   input logic [bfa_pkg::BLK_W-1:0] b, input logic bv,
                                   input logic [bfa_pkg::BLK_W-1:0] fb, input logic st);
    plan_row_t row;
    row.kind    = kind;
    row.reg_sel = bfa_pkg::REG_TOTAL;
    row.reg_val = '0;
    row.mode    = m;
    row.block   = b;
    row.want    = '{bit_value: bv, found_block: fb, status: st};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input logic reg_sel,
                                   input logic [bfa_pkg::CFG_W-1:0] val);
    plan_row_t row;
    row.kind    = ROW_CFG;
    row.reg_sel = reg_sel;
    row.reg_val = val;
    row.mode    = bfa_pkg::MODE_TEST;
    row.block   = '0;
    row.want    = '0;
    directed_plan.push_back(row);
  endfunction

  // Drop valid and hold off until every outstanding request has answered
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the allocator idle
  task automatic write_reg(input logic reg_sel, input logic [bfa_pkg::CFG_W-1:0] val);
    quiesce();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == bfa_pkg::REG_TOTAL) total_q = val;
    else first_q = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Issue one request in bursts with random gaps; typed rows supply their own expectation
  task automatic push_request(input logic [bfa_pkg::MODE_W-1:0] m,
                              input logic [bfa_pkg::BLK_W-1:0] b,
                              input bit typed, input alloc_res_t typed_want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 30) : $urandom_range(10, 1);
      gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 15) : $urandom_range(4, 0);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    last_result = predict_alloc(m, b);
    pending_results.push_back(typed ? typed_want : last_result);
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode  <= m;
    in_block <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Receiver stall pattern: short runs, occasional long stalls and long open stretches
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_on = !ready_on;
      if (ready_on) begin
        ready_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                : $urandom_range(15, 1);
      end else begin
        ready_left = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 15)
                                                : $urandom_range(6, 1);
      end
    end
    ready_left--;
    out_ready <= ready_on;
  end

  // Compare each returned result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: bit_value %0d found_block %0d status %0d",
               out_bit_value, out_found_block, out_status);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_bit_value !== head_result.bit_value) begin
          $error("bit_value: expected %0d, actual %0d", head_result.bit_value, out_bit_value);
          mismatch_count++;
        end
        if (out_found_block !== head_result.found_block) begin
          $error("found_block: expected %0d, actual %0d",
                 head_result.found_block, out_found_block);
          mismatch_count++;
        end
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    plan_row_t                  row;
    bit                         follow_set;
    logic [bfa_pkg::BLK_W-1:0]  follow_block;
    logic [bfa_pkg::MODE_W-1:0] m;
    logic [bfa_pkg::CFG_W-1:0]  tot_val;
    logic [bfa_pkg::CFG_W-1:0]  first_val;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_mode  = bfa_pkg::MODE_SET;
    in_block = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    used_bits = '0;
    total_q  = bfa_pkg::TOTAL_RST;
    first_q  = bfa_pkg::FIRST_RST;

    // After reset: all free, search starts at block 2
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd2, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_TEST, 12'd0, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_SET, 12'd2, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd4095, 1'b0, 12'd3, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_TEST, 12'd2, 1'b1, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_SET, 12'd4095, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_TEST, 12'd4095, 1'b1, 12'd0, 1'b0);
    plan_req(ROW_REQ, bfa_pkg::MODE_CLEAR, 12'd2, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_REQ, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_CLEAR, 12'd4095, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_TEST, 12'd4095, 1'b0, 12'd0, 1'b0);
    // Tiny device: no free block, and out-of-range marks and tests
    plan_cfg(bfa_pkg::REG_TOTAL, 13'd4);
    plan_req(ROW_REQ, bfa_pkg::MODE_SET, 12'd3, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_REQ, bfa_pkg::MODE_SET, 12'd2, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd0, 1'b1);
    plan_req(ROW_CHK, bfa_pkg::MODE_TEST, 12'd4, 1'b0, 12'd0, 1'b1);
    plan_req(ROW_CHK, bfa_pkg::MODE_SET, 12'd4095, 1'b0, 12'd0, 1'b1);
    plan_req(ROW_CHK, bfa_pkg::MODE_CLEAR, 12'd5, 1'b0, 12'd0, 1'b1);
    plan_req(ROW_REQ, bfa_pkg::MODE_TEST, 12'd3, 1'b0, 12'd0, 1'b0);
    // Block count above capacity saturates; search from the last block
    plan_cfg(bfa_pkg::REG_TOTAL, 13'd8191);
    plan_cfg(bfa_pkg::REG_FIRST, 13'd4095);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd4095, 1'b0);
    plan_req(ROW_REQ, bfa_pkg::MODE_SET, 12'd4095, 1'b0, 12'd0, 1'b0);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd0, 1'b1);
    // Search start beyond the end, then from block zero
    plan_cfg(bfa_pkg::REG_FIRST, 13'd8191);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd0, 1'b1);
    plan_cfg(bfa_pkg::REG_FIRST, 13'd0);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd0, 1'b0);
    // Empty device
    plan_cfg(bfa_pkg::REG_TOTAL, 13'd0);
    plan_req(ROW_CHK, bfa_pkg::MODE_TEST, 12'd0, 1'b0, 12'd0, 1'b1);
    plan_req(ROW_CHK, bfa_pkg::MODE_FIND, 12'd0, 1'b0, 12'd0, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) write_reg(row.reg_sel, row.reg_val);
      else push_request(row.mode, row.block, row.kind == ROW_CHK, row.want);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tot_val = bfa_pkg::TOTAL_RST; first_val = bfa_pkg::FIRST_RST; end
        1: begin tot_val = 13'd8191; first_val = 13'd0; end
        2: begin
          tot_val   = bfa_pkg::CFG_W'($urandom_range(400, 1));
          first_val = bfa_pkg::CFG_W'($urandom_range(int'(tot_val) + 8, 0));
        end
        3: begin
          tot_val   = bfa_pkg::CFG_W'($urandom_range(bfa_pkg::MAX_BLOCKS, 3000));
          first_val = bfa_pkg::CFG_W'($urandom_range(LAST_BLOCK, 3900));
        end
        4: begin
          tot_val   = bfa_pkg::CFG_W'($urandom_range(8191, 0));
          first_val = bfa_pkg::CFG_W'($urandom_range(8191, 0));
        end
        default: begin
          tot_val   = bfa_pkg::CFG_W'($urandom_range(200, 16));
          first_val = bfa_pkg::CFG_W'($urandom_range(8, 0));
        end
      endcase
      write_reg(bfa_pkg::REG_TOTAL, tot_val);
      write_reg(bfa_pkg::REG_FIRST, first_val);
      follow_set = 1'b0;
      follow_block = '0;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // Allocate what a find just reported, as a driver would
        if (follow_set) begin
          push_request(bfa_pkg::MODE_SET, follow_block, 1'b0, '0);
          follow_set = 1'b0;
        end else begin
          m = pick_mode();
          push_request(m, pick_block(), 1'b0, '0);
          if (m == bfa_pkg::MODE_FIND && !last_result.status && $urandom_range(9, 0) < 6) begin
            follow_set = 1'b1;
            follow_block = last_result.found_block;
          end
        end
        if ($urandom_range(149, 0) == 0) quiesce();
      end
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== bitmap_free_block_allocator_unit.f =====
rtl/bfa_pkg.sv
rtl/bfa_front.sv
rtl/bfa_back.sv
rtl/bitmap_free_block_allocator_unit.sv
tb/testbench.sv
